FILE: rtl/itbd_pkg.sv
// ----------------------------------------------------------------------------
// itbd_pkg: shared types and constants for integer_to_base_digits
// Holds widths, ASCII constants, the digit store depth and the digit encoder.
// ----------------------------------------------------------------------------
package itbd_pkg;

  localparam int unsigned ValueW    = 64;
  localparam int unsigned BaseW     = 6;
  localparam int unsigned CharW     = 8;
  localparam int unsigned CountW    = 7;
  localparam int unsigned MaxDigits = 64;
  localparam int unsigned DigW      = 6;
  localparam int unsigned IdxW      = $clog2(MaxDigits);

  localparam logic [CharW-1:0] CharZero  = 8'h30;
  localparam logic [CharW-1:0] CharLowA  = 8'h61;
  localparam logic [CharW-1:0] CharUpA   = 8'h41;
  localparam logic [CharW-1:0] CharMinus = 8'h2d;
  localparam logic [BaseW-1:0] BaseDec   = 6'd10;
  localparam logic [BaseW-1:0] BaseMin   = 6'd2;
  localparam logic [BaseW-1:0] BaseMax   = 6'd36;

  typedef enum logic [2:0] {
    StIdle, StDiv, StStore, StEmit
  } state_e;

  typedef struct packed {
    logic [CharW-1:0]  character;
    logic              last;
    logic [CountW-1:0] digit_count;
    logic              error;
  } result_t;

  function automatic logic [CharW-1:0] digit_char(input logic [DigW-1:0] d,
                                                  input logic upper);
    logic [CharW-1:0] dd;
    dd = {2'b00, d};
    if (d < 6'd10) begin
      digit_char = CharZero + dd;
    end else if (upper) begin
      digit_char = CharUpA + dd - 8'd10;
    end else begin
      digit_char = CharLowA + dd - 8'd10;
    end
  endfunction

endpackage

FILE: rtl/itbd_if.sv
// ----------------------------------------------------------------------------
// itbd_if: valid/ready stream channel
// Carries one payload of type T with a source and a sink modport.
// ----------------------------------------------------------------------------
interface itbd_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/itbd_cell.sv
// ----------------------------------------------------------------------------
// itbd_cell: one bit cell of the restoring divider chain
// Shifts the next dividend bit into its remainder slice and hands the
// partial remainder and quotient bit to the following cell.
// ----------------------------------------------------------------------------
module itbd_cell (
  input  logic [itbd_pkg::DigW:0]   rem_i,
  input  logic                      bit_i,
  input  logic [itbd_pkg::BaseW-1:0] base_i,
  output logic [itbd_pkg::DigW:0]   rem_o,
  output logic                      q_o
);
  import itbd_pkg::*;

  logic [DigW+1:0] trial;

  always_comb begin
    trial = {rem_i, bit_i};
    q_o   = (trial >= {2'b00, base_i});
    if (q_o) begin
      rem_o = (DigW+1)'(trial - {2'b00, base_i});
    end else begin
      rem_o = trial[DigW:0];
    end
  end
endmodule

FILE: rtl/itbd_divider.sv
// ----------------------------------------------------------------------------
// itbd_divider: value / base, eight bits per cycle
// A row of eight cells consumes eight dividend bits each cycle.
// ----------------------------------------------------------------------------
module itbd_divider (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [itbd_pkg::ValueW-1:0] value_i,
  input  logic [itbd_pkg::BaseW-1:0]  base_i,
  output logic                        done_o,
  output logic [itbd_pkg::ValueW-1:0] quot_o,
  output logic [itbd_pkg::DigW-1:0]   rem_o
);
  import itbd_pkg::*;

  localparam int unsigned Cells = 8;
  localparam int unsigned Steps = ValueW / Cells;

  logic [ValueW-1:0] sh_q, sh_d;
  logic [DigW:0]     rem_q, rem_d;
  logic [$clog2(Steps+1)-1:0] cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic [DigW:0]     chain [Cells+1];
  logic [Cells-1:0]  qb;

  assign chain[0] = rem_q;
  for (genvar g = 0; g < Cells; g++) begin : g_cell
    itbd_cell u_cell (
      .rem_i (chain[g]),
      .bit_i (sh_q[ValueW-1-g]),
      .base_i(base_i),
      .rem_o (chain[g+1]),
      .q_o   (qb[Cells-1-g])
    );
  end

  always_comb begin
    sh_d   = sh_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      sh_d   = value_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      sh_d  = {sh_q[ValueW-Cells-1:0], qb};
      rem_d = chain[Cells];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == ($clog2(Steps+1))'(Steps - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    rem_q <= rem_d;
  end

  assign done_o = busy_q && (cnt_q == ($clog2(Steps+1))'(Steps - 1));
  assign quot_o = {sh_q[ValueW-Cells-1:0], qb};
  assign rem_o  = chain[Cells][DigW-1:0];
endmodule

FILE: rtl/integer_to_base_digits_top.sv
// ----------------------------------------------------------------------------
// integer_to_base_digits_top: integer to ASCII digit string in base 2..36
// Divides repeatedly by the base, stacks the digits, then streams them out
// most significant first with the last character flagged.
// ----------------------------------------------------------------------------
// Timing: each digit takes a divide plus a store before output starts, then
//   one character per cycle while the receiver is ready.
// Throughput: one item at a time; the 8-bit-per-cycle divider row sets the pace.
// Reset: rst_ni clears the control state; the digit store needs no clearing.
module integer_to_base_digits_top (
  input  logic  clk_i,
  input  logic  rst_ni,
  itbd_if.sink   in_i,
  itbd_if.source out_o
);
  import itbd_pkg::*;

  // Input payload: {command, value, base}
  state_e state_q, state_d;

  logic              upper_q;
  logic [BaseW-1:0]  base_q;
  logic [CountW-1:0] n_q, n_d;
  logic [CountW-1:0] pos_q, pos_d;
  logic              sign_pend_q, sign_pend_d;
  logic [CharW-1:0]  mem_q [MaxDigits];
  logic [CharW-1:0]  rd_q;

  logic              div_start, div_done;
  logic [ValueW-1:0] quot;
  logic [DigW-1:0]   rem;
  logic [ValueW-1:0] quot_q;

  logic              in_cmd;
  logic [ValueW-1:0] in_val;
  logic [BaseW-1:0]  in_base;
  logic              bad_base;
  logic [31:0]       low;
  logic              neg;
  logic [ValueW-1:0] start_val;

  result_t           res_q, res_d;
  logic              ovalid_q, ovalid_d;
  logic              take;

  assign in_cmd   = in_i.data[ValueW+BaseW];
  assign in_val   = in_i.data[ValueW+BaseW-1:BaseW];
  assign in_base  = in_i.data[BaseW-1:0];
  assign bad_base = (in_base < BaseMin) || (in_base > BaseMax);
  assign low      = in_val[31:0];
  assign neg      = !in_cmd && (in_base == BaseDec) && low[31];

  always_comb begin
    if (in_cmd) begin
      start_val = in_val;
    end else if (neg) begin
      start_val = {32'd0, 32'd0 - low};
    end else begin
      start_val = {32'd0, low};
    end
  end

  // Output register frees when taken or empty.
  assign take     = !ovalid_q || out_o.ready;
  assign in_i.ready = (state_q == StIdle) && take;

  assign div_start = (state_q == StIdle) && in_i.valid && take && !bad_base;

  itbd_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start || (state_q == StStore && quot_q != '0 )),
    .value_i(div_start ? start_val : quot_q),
    .base_i (div_start ? in_base : base_q),
    .done_o (div_done),
    .quot_o (quot),
    .rem_o  (rem)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (div_start) state_d = StDiv;
      StDiv:   if (div_done) state_d = StStore;
      StStore: if (quot_q == '0) state_d = StEmit;
               else state_d = StDiv;
      StEmit:  if (take && !sign_pend_q && pos_q == CountW'(1)) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // Datapath and output control.
  always_comb begin
    n_d         = n_q;
    pos_d       = pos_q;
    sign_pend_d = sign_pend_q;
    res_d       = res_q;
    ovalid_d    = ovalid_q && !out_o.ready;
    unique case (state_q)
      StIdle: begin
        if (in_i.valid && take) begin
          if (bad_base) begin
            ovalid_d = 1'b1;
            res_d    = '{character: '0, last: 1'b1, digit_count: '0, error: 1'b1};
          end else begin
            n_d         = '0;
            sign_pend_d = neg;
          end
        end
      end
      StStore: begin
        // Keep only the lowest MaxDigits digits: stop counting once full.
        if (n_q != CountW'(MaxDigits)) n_d = n_q + 1'b1;
        pos_d = (n_q != CountW'(MaxDigits)) ? n_q + 1'b1 : n_q;
      end
      StEmit: begin
        if (take) begin
          ovalid_d = 1'b1;
          if (sign_pend_q) begin
            sign_pend_d = 1'b0;
            res_d = '{character: CharMinus, last: 1'b0, digit_count: '0, error: 1'b0};
          end else begin
            pos_d = pos_q - 1'b1;
            res_d = '{character: rd_q, last: (pos_q == CountW'(1)),
                      digit_count: (pos_q == CountW'(1)) ? n_q : '0, error: 1'b0};
          end
        end
      end
      default: ;
    endcase
  end

  // Read address: next digit to send, registered for the emit state.
  logic [IdxW-1:0] raddr;
  always_comb begin
    if (state_q == StEmit && take && !sign_pend_q) begin
      raddr = IdxW'(pos_q - CountW'(2));
    end else begin
      raddr = IdxW'(pos_d - CountW'(1));
    end
  end

  // Digit store: written least significant digit first as each divide
  // finishes, so the store cycle can already read the newest digit back;
  // digits beyond MaxDigits are dropped.
  always_ff @(posedge clk_i) begin
    if (state_q == StDiv && div_done) begin
      quot_q <= quot;
      if (n_q != CountW'(MaxDigits)) begin
        mem_q[n_q[IdxW-1:0]] <= digit_char(rem, upper_q);
      end
    end
    rd_q <= mem_q[raddr];
    if (div_start) begin
      upper_q <= in_cmd;
      base_q  <= in_base;
    end
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      ovalid_q    <= 1'b0;
      n_q         <= '0;
      pos_q       <= '0;
      sign_pend_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ovalid_q    <= ovalid_d;
      n_q         <= n_d;
      pos_q       <= pos_d;
      sign_pend_q <= sign_pend_d;
    end
  end

  assign out_o.valid = ovalid_q;
  assign out_o.data  = res_q;
endmodule

FILE: tb/itbd_tb_pkg.sv
// ----------------------------------------------------------------------------
// itbd_tb_pkg: request type and command codes for the digit converter bench
// Defines the input payload carried on the request channel.
// ----------------------------------------------------------------------------
package itbd_tb_pkg;

  import itbd_pkg::*;

  typedef enum logic {
    CmdSigned32   = 1'b0,
    CmdUnsigned64 = 1'b1
  } conv_cmd_e;

  typedef struct packed {
    logic              command;
    logic [ValueW-1:0] value;
    logic [BaseW-1:0]  base;
  } conv_req_t;

endpackage

FILE: tb/integer_to_base_digits_checker.sv
// ----------------------------------------------------------------------------
// integer_to_base_digits_checker: digit string predictor and result compare
// Watches both channels, predicts the characters of every accepted request
// and compares each accepted character with the oldest expected one.
// ----------------------------------------------------------------------------
module integer_to_base_digits_checker
  import itbd_pkg::*;
  import itbd_tb_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  itbd_if      req_i,
  itbd_if      chr_i,
  output int   fail_count_o,
  output int   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  result_t expected_chars[$];

  function automatic logic [CharW-1:0] ascii_digit(logic [ValueW-1:0] d, logic upper);
    if (d < 10) return CharZero + d[CharW-1:0];
    return (upper ? CharUpA : CharLowA) + d[CharW-1:0] - 8'd10;
  endfunction

  // Push the characters one request produces onto the expected queue.
  task automatic predict_digits(conv_req_t r);
    logic [ValueW-1:0] v;
    logic [ValueW-1:0] b;
    logic [CharW-1:0]  digs[MaxDigits];
    logic              neg;
    logic              upper;
    int                n;
    result_t           e;
    b = {58'd0, r.base};
    neg = 1'b0;
    n = 0;
    if (r.base < BaseMin || r.base > BaseMax) begin
      e = '{character: '0, last: 1'b1, digit_count: '0, error: 1'b1};
      expected_chars.push_back(e);
      return;
    end
    upper = (r.command == CmdUnsigned64);
    v = r.value;
    if (r.command == CmdSigned32) begin
      v = {32'd0, r.value[31:0]};
      if (r.base == BaseDec && v[31]) begin
        neg = 1'b1;
        v = 64'h1_0000_0000 - v;
      end
    end
    do begin
      if (n < MaxDigits) digs[n] = ascii_digit(v % b, upper);
      n++;
      v = v / b;
    end while (v != 0);
    if (n > MaxDigits) n = MaxDigits;
    if (neg) begin
      e = '{character: CharMinus, last: 1'b0, digit_count: '0, error: 1'b0};
      expected_chars.push_back(e);
    end
    for (int i = n - 1; i >= 0; i--) begin
      e.character   = digs[i];
      e.last        = (i == 0);
      e.digit_count = (i == 0) ? CountW'(n) : '0;
      e.error       = 1'b0;
      expected_chars.push_back(e);
    end
  endtask

  assign pending_o = expected_chars.size();

  always @(posedge clk_i or negedge rst_ni) begin
    result_t got;
    result_t want;
    if (!rst_ni) begin
      fail_count_o <= 0;
    end else begin
      if (req_i.valid && req_i.ready) predict_digits(req_i.data);
      if (chr_i.valid && chr_i.ready) begin
        got = chr_i.data;
        if (expected_chars.size() == 0) begin
          if (fail_count_o < 10) $display("unexpected char %h last %b cnt %0d err %b",
                                          got.character, got.last, got.digit_count, got.error);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_chars.pop_front();
          if (got !== want) begin
            if (fail_count_o < 10)
              $display("mismatch: exp char %h last %b cnt %0d err %b, got %h %b %0d %b",
                       want.character, want.last, want.digit_count, want.error,
                       got.character, got.last, got.digit_count, got.error);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

FILE: tb/integer_to_base_digits_top_tb.sv
// ----------------------------------------------------------------------------
// integer_to_base_digits_top_tb: stimulus and verdict for the digit converter
// Sends directed then random conversion requests with random gaps, stalls
// the character stream at random, and reports the checker's outcome.
// ----------------------------------------------------------------------------
module integer_to_base_digits_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import itbd_pkg::*;
  import itbd_tb_pkg::*;

  localparam int IdleLimit  = 20000;
  localparam int LongHold   = 3000;
  localparam int RandomReqs = 300;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   idle_cycles;
  bit   hold_request;

  itbd_if #(.T(conv_req_t)) req_if ();
  itbd_if #(.T(result_t))   chr_if ();

  integer_to_base_digits_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (chr_if)
  );

  integer_to_base_digits_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_if),
    .chr_i        (chr_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // Short gaps mostly, a long one now and then.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Offer one request and hold it until the transfer happens.
  task automatic send_req(logic cmd, logic [ValueW-1:0] val, logic [BaseW-1:0] base);
    int g;
    req_if.valid <= 1'b1;
    req_if.data  <= '{command: cmd, value: val, base: base};
    do @(negedge clk_i); while (!req_if.ready);
    @(posedge clk_i);
    g = gap_len();
    if (g > 0) begin
      req_if.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  function automatic logic [ValueW-1:0] rand_value();
    case ($urandom_range(0, 5))
      0: return {32'd0, $urandom_range(0, 40)};
      1: return {$urandom, $urandom};
      2: return {$urandom, 1'b1, 31'($urandom_range(0, 3))};
      3: return {32'hffff_ffff, 32'hffff_ffff - $urandom_range(0, 3)};
      4: return {$urandom, 1'b0, 31'(31'h7fff_ffff - $urandom_range(0, 3))};
      default: return {32'd0, $urandom};
    endcase
  endfunction

  function automatic logic [BaseW-1:0] rand_base();
    if ($urandom_range(0, 9) != 0) return BaseW'($urandom_range(2, 36));
    if ($urandom_range(0, 1) != 0) return BaseW'($urandom_range(0, 1));
    return BaseW'($urandom_range(37, 63));
  endfunction

  // Receiver: alternate between stall-free stretches and random stalls;
  // honor a long hold-off when the sender asks for one.
  initial begin
    int mode_left;
    bit stall_mode;
    chr_if.ready = 1'b0;
    mode_left = 0;
    stall_mode = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        chr_if.ready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
        hold_request = 1'b0;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 2) != 0;
          mode_left = $urandom_range(20, 300);
        end
        mode_left--;
        if (!stall_mode) chr_if.ready <= 1'b1;
        else chr_if.ready <= (gap_len() == 0);
      end
    end
  end

  // Watchdog: count cycles with no transfer on either channel.
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (chr_if.valid && chr_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    rst_ni       = 1'b0;
    idle_cycles  = 0;
    hold_request = 1'b0;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: bad bases, zero, extremes, sign handling, letter case.
    send_req(CmdSigned32,   64'd5, 6'd0);
    send_req(CmdUnsigned64, 64'd5, 6'd1);
    send_req(CmdSigned32,   64'd5, 6'd37);
    send_req(CmdUnsigned64, '1,    6'd63);
    send_req(CmdSigned32,   64'd0, 6'd10);
    send_req(CmdUnsigned64, 64'd0, 6'd2);
    send_req(CmdUnsigned64, '1,    6'd2);
    send_req(CmdUnsigned64, '1,    6'd36);
    send_req(CmdUnsigned64, '1,    6'd10);
    send_req(CmdSigned32,   64'hdead_beef_8000_0000, 6'd10);
    send_req(CmdSigned32,   64'hffff_ffff_ffff_ffff, 6'd10);
    send_req(CmdSigned32,   64'h0000_0000_ffff_ffff, 6'd16);
    send_req(CmdSigned32,   64'h0000_0000_7fff_ffff, 6'd10);
    send_req(CmdSigned32,   64'h0000_0000_ffff_ffff, 6'd36);
    send_req(CmdSigned32,   64'h0000_0000_8000_0000, 6'd2);
    send_req(CmdSigned32,   64'd35, 6'd36);
    send_req(CmdUnsigned64, 64'd35, 6'd36);
    send_req(CmdUnsigned64, 64'hcafe_f00d_1234_5678, 6'd16);
    send_req(CmdSigned32,   64'h0000_0000_8000_0000, 6'd8);

    for (int i = 0; i < RandomReqs; i++) begin
      // Stall the receiver for a long stretch while requests keep coming.
      if (i == 100) hold_request = 1'b1;
      // Let the block drain completely once.
      if (i == 200) begin
        req_if.valid <= 1'b0;
        @(posedge clk_i);
        while (pending != 0) @(posedge clk_i);
        repeat (800) @(posedge clk_i);
      end
      send_req(logic'($urandom_range(0, 1)), rand_value(), rand_base());
    end
    req_if.valid <= 1'b0;
    @(posedge clk_i);

    while (pending != 0) @(posedge clk_i);
    repeat (800) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
